// ----- design/rtpc_pkg.sv -----
// Shared constants, types and helper functions for the RGB to terminal palette code block.
package rtpc_pkg;

    // Palette size and the widths that follow from it.
    localparam int PALETTE_ENTRIES = 16;
    localparam int PAL_IDX_W       = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

    // Fixed field widths.
    localparam int IDX_W   = 4;
    localparam int CHAN_W  = 8;
    localparam int CODE_W  = 8;
    localparam int SGR_W   = 7;
    localparam int KIND_W  = 2;
    localparam int ENTRY_W = 3 * CHAN_W;
    localparam int SQ_W    = 2 * CHAN_W;
    localparam int DIST_W  = 26;
    localparam int LEVEL_W = 3;

    // Stream widths.
    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 2;

    // Luma weights for the distance, scaled by one thousand.
    localparam logic [9:0] WEIGHT_RED   = 10'd299;
    localparam logic [9:0] WEIGHT_GREEN = 10'd587;
    localparam logic [9:0] WEIGHT_BLUE  = 10'd114;

    // Color cube constants: one level per 51 counts of a channel.
    localparam int CUBE_LEVELS = 5;
    localparam int CUBE_STEP   = 255 / CUBE_LEVELS;
    localparam int CUBE_BASE   = 16;
    localparam int CUBE_RED_MUL   = 36;
    localparam int CUBE_GREEN_MUL = 6;

    // SGR numbering.
    localparam int SGR_FG_BASE   = 30;
    localparam int SGR_FG_BRIGHT = 90;
    localparam int SGR_BG_OFFSET = 10;
    localparam int BRIGHT_FIRST  = 8;

    // Command codes.
    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_CONVERT = 1'b1;

    // Color depth modes, also used as the result kind.
    typedef enum logic [1:0] {
        MODE_NONE    = 2'd0,
        MODE_PALETTE = 2'd1,
        MODE_CUBE    = 2'd2,
        MODE_DIRECT  = 2'd3
    } depth_mode_t;

    // Request into the distance unit: one palette entry per cycle.
    typedef struct packed {
        logic                 valid;
        logic                 last;
        logic [PAL_IDX_W-1:0] idx;
        logic [ENTRY_W-1:0]   entry;
    } dist_req_t;

    // Response from the distance unit.
    typedef struct packed {
        logic                 valid;
        logic                 last;
        logic [PAL_IDX_W-1:0] idx;
        logic [DIST_W-1:0]    distance;
    } dist_rsp_t;

    // Scale one channel to a cube level, floor(c * 5 / 255).
    function automatic logic [LEVEL_W-1:0] cube_level(input logic [CHAN_W-1:0] c);
        logic [LEVEL_W-1:0] lvl;
        lvl = '0;
        for (int k = 1; k <= CUBE_LEVELS; k++) begin
            if (c >= CHAN_W'(k * CUBE_STEP)) begin
                lvl = LEVEL_W'(k);
            end
        end
        return lvl;
    endfunction

    // Cube code 16 + 36*ri + 6*gi + bi.
    function automatic logic [CODE_W-1:0] cube_code(input logic [CHAN_W-1:0] r,
                                                    input logic [CHAN_W-1:0] g,
                                                    input logic [CHAN_W-1:0] b);
        logic [CODE_W-1:0] ri;
        logic [CODE_W-1:0] gi;
        logic [CODE_W-1:0] bi;
        ri = CODE_W'(cube_level(r));
        gi = CODE_W'(cube_level(g));
        bi = CODE_W'(cube_level(b));
        return CODE_W'(CUBE_BASE) + ri * CODE_W'(CUBE_RED_MUL)
             + gi * CODE_W'(CUBE_GREEN_MUL) + bi;
    endfunction

    // SGR number for a sixteen-color index, foreground or background.
    function automatic logic [SGR_W-1:0] sgr_code(input logic [IDX_W-1:0] code,
                                                  input logic             bg);
        logic [SGR_W-1:0] base;
        base = (code >= IDX_W'(BRIGHT_FIRST)) ? SGR_W'(SGR_FG_BRIGHT - BRIGHT_FIRST)
                                              : SGR_W'(SGR_FG_BASE);
        return base + SGR_W'(code) + (bg ? SGR_W'(SGR_BG_OFFSET) : '0);
    endfunction

endpackage

// ----- design/rgb_to_terminal_palette_code.sv -----
// Top level: maps an RGB color to a terminal color code by the configured depth.
//
// Input stream (s_*): each transfer is either a palette load or a color to
// convert, selected by s_tuser[0]; loads give no result. Output stream (m_*):
// one transfer per conversion in palette, cube and direct mode; none in
// no-color mode. cfg_we/cfg_wdata set the depth mode.
//
// A cube or direct conversion is registered at acceptance and moves into the
// output register once that register is free; the next item is taken after
// that move. A sixteen-color conversion scans the palette one entry per cycle
// into a three-stage distance pipeline; after the scan and the pipeline, the
// drain state takes the winner, and the result moves into the output register
// once that register is free. The next item is taken after that move, and
// s_tready is low meanwhile.
//
// Reset clears the control state and selects no-color mode; palette entries
// are not cleared and must be loaded before sixteen-color conversion.
// When the receiver stalls, the result waits in the output register; the block
// still takes loads and starts the next conversion, which then waits for the
// output register to free up before it finishes.
module rgb_to_terminal_palette_code (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Configuration: depth mode.
    input  logic                            cfg_we,
    input  logic [1:0]                      cfg_wdata,
    // Input stream.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // entry_index[3:0], red[11:4], green[19:12], blue[27:20], zero fill[31:28]
    input  logic [rtpc_pkg::S_TDATA_W-1:0]  s_tdata,
    // command[0], is_background[1]
    input  logic [rtpc_pkg::S_TUSER_W-1:0]  s_tuser,
    // Output stream.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // colour_code[7:0], sgr_number[14:8], red_out[22:15], green_out[30:23],
    // blue_out[38:31], zero fill[39]
    output logic [rtpc_pkg::M_TDATA_W-1:0]  m_tdata,
    // kind[1:0]
    output logic [rtpc_pkg::M_TUSER_W-1:0]  m_tuser
);
    import rtpc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    localparam logic [PAL_IDX_W-1:0] LAST_ENTRY = PAL_IDX_W'(PALETTE_ENTRIES - 1);

    state_t               state_reg;
    depth_mode_t          depth_mode_reg;

    logic                 in_command;
    logic [IDX_W-1:0]     in_entry_index;
    logic [CHAN_W-1:0]    in_red;
    logic [CHAN_W-1:0]    in_green;
    logic [CHAN_W-1:0]    in_blue;
    logic                 in_is_background;
    logic                 in_xfer;
    logic                 load_wr;

    logic [PAL_IDX_W-1:0] scan_idx_reg;
    logic [ENTRY_W-1:0]   entry_data;
    logic                 req_valid_reg;
    logic                 req_last_reg;
    logic [PAL_IDX_W-1:0] req_idx_reg;
    dist_req_t            dist_req;
    dist_rsp_t            dist_rsp;

    logic [CHAN_W-1:0]    red_reg;
    logic [CHAN_W-1:0]    green_reg;
    logic [CHAN_W-1:0]    blue_reg;
    logic                 bg_reg;

    logic [DIST_W-1:0]    min_dist_reg;
    logic [PAL_IDX_W-1:0] best_idx_reg;
    logic                 best_take;
    logic [PAL_IDX_W-1:0] best_idx_next;

    depth_mode_t          kind_reg;
    logic [CODE_W-1:0]    res_code_reg;
    logic [CHAN_W-1:0]    res_red_reg;
    logic [CHAN_W-1:0]    res_green_reg;
    logic [CHAN_W-1:0]    res_blue_reg;
    logic                 emit_fire;

    logic                 m_tvalid_reg;
    depth_mode_t          m_kind_reg;
    logic [CODE_W-1:0]    m_code_reg;
    logic [SGR_W-1:0]     m_sgr_reg;
    logic [CHAN_W-1:0]    m_red_reg;
    logic [CHAN_W-1:0]    m_green_reg;
    logic [CHAN_W-1:0]    m_blue_reg;

    // Unpack the input transfer.
    assign in_entry_index   = s_tdata[IDX_W-1:0];
    assign in_red           = s_tdata[IDX_W+CHAN_W-1:IDX_W];
    assign in_green         = s_tdata[IDX_W+2*CHAN_W-1:IDX_W+CHAN_W];
    assign in_blue          = s_tdata[IDX_W+3*CHAN_W-1:IDX_W+2*CHAN_W];
    assign in_command       = s_tuser[0];
    assign in_is_background = s_tuser[1];

    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;

    // Loads beyond the palette are dropped.
    assign load_wr = in_xfer && (in_command == CMD_LOAD)
                     && ({1'b0, in_entry_index} < (IDX_W + 1)'(PALETTE_ENTRIES));

    rtpc_palette #(
        .WIDTH (ENTRY_W),
        .DEPTH (PALETTE_ENTRIES)
    ) u_palette (
        .aclk    (aclk),
        .wr_en   (load_wr),
        .wr_idx  (in_entry_index[PAL_IDX_W-1:0]),
        .wr_data ({in_red, in_green, in_blue}),
        .rd_idx  (scan_idx_reg),
        .rd_data (entry_data)
    );

    // Feed one palette entry per scan cycle into the distance unit, in step with the read data.
    assign dist_req.valid = req_valid_reg;
    assign dist_req.last  = req_last_reg;
    assign dist_req.idx   = req_idx_reg;
    assign dist_req.entry = entry_data;

    rtpc_dist_unit u_dist (
        .aclk    (aclk),
        .aresetn (aresetn),
        .red     (red_reg),
        .green   (green_reg),
        .blue    (blue_reg),
        .req     (dist_req),
        .rsp     (dist_rsp)
    );

    // The first entry always wins; later ones only on a strictly smaller distance.
    assign best_take     = dist_rsp.valid
                           && ((dist_rsp.idx == '0) || (dist_rsp.distance < min_dist_reg));
    assign best_idx_next = best_take ? dist_rsp.idx : best_idx_reg;

    assign emit_fire = (state_reg == ST_EMIT) && (!m_tvalid_reg || m_tready);

    // Sequencer, configuration register and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            depth_mode_reg <= MODE_NONE;
            scan_idx_reg   <= '0;
            req_valid_reg  <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                depth_mode_reg <= depth_mode_t'(cfg_wdata);
            end

            // Request tags are registered from the palette read address, in line with the registered read data.
            req_valid_reg <= (state_reg == ST_SCAN);
            req_last_reg  <= (scan_idx_reg == LAST_ENTRY);
            req_idx_reg   <= scan_idx_reg;

            if (best_take) begin
                min_dist_reg <= dist_rsp.distance;
                best_idx_reg <= dist_rsp.idx;
            end

            // The output register empties on a transfer unless a new result moves in.
            if (m_tvalid_reg && m_tready && !emit_fire) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (in_xfer && (in_command == CMD_CONVERT)) begin
                        kind_reg      <= depth_mode_reg;
                        red_reg       <= in_red;
                        green_reg     <= in_green;
                        blue_reg      <= in_blue;
                        bg_reg        <= in_is_background;
                        res_code_reg  <= (depth_mode_reg == MODE_CUBE)
                                         ? cube_code(in_red, in_green, in_blue) : '0;
                        res_red_reg   <= (depth_mode_reg == MODE_DIRECT) ? in_red   : '0;
                        res_green_reg <= (depth_mode_reg == MODE_DIRECT) ? in_green : '0;
                        res_blue_reg  <= (depth_mode_reg == MODE_DIRECT) ? in_blue  : '0;
                        case (depth_mode_reg) inside
                            MODE_PALETTE: begin
                                scan_idx_reg <= '0;
                                state_reg    <= ST_SCAN;
                            end
                            MODE_CUBE, MODE_DIRECT: begin
                                state_reg <= ST_EMIT;
                            end
                            default: begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_SCAN: begin
                    if (scan_idx_reg == LAST_ENTRY) begin
                        state_reg <= ST_DRAIN;
                    end else begin
                        scan_idx_reg <= scan_idx_reg + 1'b1;
                    end
                end
                ST_DRAIN: begin
                    if (dist_rsp.valid && dist_rsp.last) begin
                        res_code_reg <= CODE_W'(best_idx_next);
                        state_reg    <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (emit_fire) begin
                        m_tvalid_reg <= 1'b1;
                        m_kind_reg   <= kind_reg;
                        m_code_reg   <= res_code_reg;
                        m_sgr_reg    <= (kind_reg == MODE_PALETTE)
                                        ? sgr_code(res_code_reg[IDX_W-1:0], bg_reg) : '0;
                        m_red_reg    <= res_red_reg;
                        m_green_reg  <= res_green_reg;
                        m_blue_reg   <= res_blue_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    // Pack the result transfer.
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, m_blue_reg, m_green_reg, m_red_reg, m_sgr_reg, m_code_reg};
    assign m_tuser  = m_kind_reg;

endmodule

// ----- design/rtpc_palette.sv -----
// Generic RAM with one write port and one registered read port, used for the palette.
module rtpc_palette #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_idx,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_idx,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Entries hold whatever was last written; no reset. The read data is registered from the address.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            entry_reg[wr_idx] <= wr_data;
        end
        rd_data_reg <= entry_reg[rd_idx];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/rtpc_dist_unit.sv -----
// Pipelined weighted squared distance unit, shared by every palette entry of a scan.
module rtpc_dist_unit (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [rtpc_pkg::CHAN_W-1:0]  red,
    input  logic [rtpc_pkg::CHAN_W-1:0]  green,
    input  logic [rtpc_pkg::CHAN_W-1:0]  blue,
    input  rtpc_pkg::dist_req_t          req,
    output rtpc_pkg::dist_rsp_t          rsp
);
    import rtpc_pkg::*;

    function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                   input logic [CHAN_W-1:0] b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

    logic [CHAN_W-1:0]    dr;
    logic [CHAN_W-1:0]    dg;
    logic [CHAN_W-1:0]    db;

    logic                 s1_valid_reg;
    logic                 s1_last_reg;
    logic [PAL_IDX_W-1:0] s1_idx_reg;
    logic [SQ_W-1:0]      sq_r_reg;
    logic [SQ_W-1:0]      sq_g_reg;
    logic [SQ_W-1:0]      sq_b_reg;

    logic                 s2_valid_reg;
    logic                 s2_last_reg;
    logic [PAL_IDX_W-1:0] s2_idx_reg;
    logic [DIST_W-1:0]    wr_reg;
    logic [DIST_W-1:0]    wg_reg;
    logic [DIST_W-1:0]    wb_reg;

    logic                 s3_valid_reg;
    logic                 s3_last_reg;
    logic [PAL_IDX_W-1:0] s3_idx_reg;
    logic [DIST_W-1:0]    dist_reg;

    // Channel differences against the entry being scanned.
    assign dr = abs_diff(red,   req.entry[3*CHAN_W-1:2*CHAN_W]);
    assign dg = abs_diff(green, req.entry[2*CHAN_W-1:CHAN_W]);
    assign db = abs_diff(blue,  req.entry[CHAN_W-1:0]);

    // Valid bits of the three stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= req.valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // Stage one squares, stage two weights, stage three sums.
    always_ff @(posedge aclk) begin
        s1_last_reg <= req.last;
        s1_idx_reg  <= req.idx;
        sq_r_reg    <= SQ_W'(dr) * SQ_W'(dr);
        sq_g_reg    <= SQ_W'(dg) * SQ_W'(dg);
        sq_b_reg    <= SQ_W'(db) * SQ_W'(db);

        s2_last_reg <= s1_last_reg;
        s2_idx_reg  <= s1_idx_reg;
        wr_reg      <= DIST_W'(sq_r_reg) * DIST_W'(WEIGHT_RED);
        wg_reg      <= DIST_W'(sq_g_reg) * DIST_W'(WEIGHT_GREEN);
        wb_reg      <= DIST_W'(sq_b_reg) * DIST_W'(WEIGHT_BLUE);

        s3_last_reg <= s2_last_reg;
        s3_idx_reg  <= s2_idx_reg;
        dist_reg    <= wr_reg + wg_reg + wb_reg;
    end

    assign rsp.valid    = s3_valid_reg;
    assign rsp.last     = s3_last_reg;
    assign rsp.idx      = s3_idx_reg;
    assign rsp.distance = dist_reg;

endmodule

// ----- verif/rgb_to_terminal_palette_code_tb.sv -----
// Testbench for rgb_to_terminal_palette_code: directed and random stream traffic.
`timescale 1ns / 100ps

module rgb_to_terminal_palette_code_tb;
    import rtpc_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int MAX_GAP       = 18;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 2000;

    // One expected result of a conversion.
    typedef struct packed {
        depth_mode_t        kind;
        logic [CODE_W-1:0]  code;
        logic [SGR_W-1:0]   sgr;
        logic [CHAN_W-1:0]  red;
        logic [CHAN_W-1:0]  green;
        logic [CHAN_W-1:0]  blue;
    } term_code_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_we;
    logic [1:0]             cfg_wdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic [S_TUSER_W-1:0]   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [M_TUSER_W-1:0]   m_tuser;

    // Local copy of the block's state.
    logic [ENTRY_W-1:0]     palette_copy [PALETTE_ENTRIES];
    depth_mode_t            depth_copy;

    term_code_t             expected_codes [$];
    term_code_t             oldest_code;
    int                     error_count = 0;
    int                     quiet_cycles = 0;
    bit                     send_burst = 1'b0;
    bit                     recv_burst = 1'b0;
    bit                     hold_req = 1'b0;

    rgb_to_terminal_palette_code u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // Free-running clock.
    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // Idle cycles before a transfer: none in a burst, often none otherwise.
    function automatic int draw_gap(input bit burst);
        if (burst || $urandom_range(0, 3) == 0) begin
            return 0;
        end
        return $urandom_range(0, MAX_GAP);
    endfunction

    // Channel value biased toward the extremes and the cube level edges.
    function automatic logic [CHAN_W-1:0] pick_channel();
        int level;
        level = $urandom_range(1, CUBE_LEVELS);
        case ($urandom_range(0, 7))
            0: begin
                return '0;
            end
            1: begin
                return '1;
            end
            2: begin
                return CHAN_W'(level * CUBE_STEP - $urandom_range(0, 1));
            end
            default: begin
                return CHAN_W'($urandom_range(0, 255));
            end
        endcase
    endfunction

    // Updates the local state for one accepted item and works out its result.
    // Returns 1 when the item is expected to produce a result.
    function automatic bit predict_term_code(input logic cmd, input logic [IDX_W-1:0] idx,
                                             input logic [CHAN_W-1:0] r,
                                             input logic [CHAN_W-1:0] g,
                                             input logic [CHAN_W-1:0] b,
                                             input logic bg, output term_code_t res);
        int unsigned min_score;
        int unsigned score;
        int          best_idx;
        int          dr;
        int          dg;
        int          db;
        res = '0;
        res.kind = depth_copy;
        if (cmd == CMD_LOAD) begin
            if (idx < PALETTE_ENTRIES) begin
                palette_copy[idx] = {r, g, b};
            end
            return 1'b0;
        end
        case (depth_copy)
            MODE_PALETTE: begin
                // Strict less-than keeps the lowest index on a tie.
                min_score = 32'hFFFF_FFFF;
                best_idx = 0;
                for (int i = 0; i < PALETTE_ENTRIES; i++) begin
                    dr = int'(r) - int'(palette_copy[i][23:16]);
                    dg = int'(g) - int'(palette_copy[i][15:8]);
                    db = int'(b) - int'(palette_copy[i][7:0]);
                    score = 299 * dr * dr + 587 * dg * dg + 114 * db * db;
                    if (score < min_score) begin
                        min_score = score;
                        best_idx = i;
                    end
                end
                res.code = CODE_W'(best_idx);
                res.sgr = (best_idx < 8) ? SGR_W'(30 + best_idx) : SGR_W'(90 + best_idx - 8);
                if (bg) begin
                    res.sgr = res.sgr + SGR_W'(10);
                end
            end
            MODE_CUBE: begin
                res.code = CODE_W'(16 + 36 * (int'(r) * 5 / 255) + 6 * (int'(g) * 5 / 255)
                                   + int'(b) * 5 / 255);
            end
            MODE_DIRECT: begin
                res.red = r;
                res.green = g;
                res.blue = b;
            end
            default: begin
                return 1'b0;
            end
        endcase
        return 1'b1;
    endfunction

    // Offers one item and waits for its transfer; the expectation is taken at acceptance.
    task automatic send_item(input logic cmd, input logic [IDX_W-1:0] idx,
                             input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                             input logic [CHAN_W-1:0] b, input logic bg);
        int         gap;
        term_code_t res;
        gap = draw_gap(send_burst);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, b, g, r, idx};
        s_tuser  <= {bg, cmd};
        do begin
            @(posedge aclk);
        end while (!s_tready);
        if (predict_term_code(cmd, idx, r, g, b, bg, res)) begin
            expected_codes = {expected_codes, res};
        end
    endtask

    // Stops offering and waits until every expected result has arrived and the block settles.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_codes.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Writes the depth mode once the block is idle.
    task automatic set_depth(input depth_mode_t mode);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= mode;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        depth_copy = mode;
    endtask

    // Loads every palette entry (in no-color mode) and checks that conversions give nothing.
    task automatic test_load_palette();
        logic [ENTRY_W-1:0] colors [PALETTE_ENTRIES];
        colors = '{24'h000000, 24'h800000, 24'h008000, 24'h808000,
                   24'h000080, 24'h800080, 24'h008080, 24'hC0C0C0,
                   24'h808080, 24'h800000, 24'h00FF00, 24'hFFFF00,
                   24'h0000FF, 24'hFF00FF, 24'h00FFFF, 24'hFFFFFF};
        set_depth(MODE_NONE);
        send_item(CMD_CONVERT, 4'hF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        for (int i = 0; i < PALETTE_ENTRIES; i++) begin
            send_item(CMD_LOAD, IDX_W'(i), colors[i][23:16], colors[i][15:8], colors[i][7:0],
                      1'(i % 2));
        end
        send_item(CMD_CONVERT, 4'h0, 8'h00, 8'h00, 8'h00, 1'b0);
    endtask

    // Nearest palette entry: exact hits, a tie between duplicate entries, bright indices.
    task automatic test_sixteen_colour();
        set_depth(MODE_PALETTE);
        send_item(CMD_CONVERT, 4'h0, 8'h00, 8'h00, 8'h00, 1'b0);
        send_item(CMD_CONVERT, 4'h0, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        send_item(CMD_CONVERT, 4'h0, 8'h80, 8'h00, 8'h00, 1'b0);
        send_item(CMD_CONVERT, 4'h0, 8'hFF, 8'hFF, 8'h10, 1'b1);
        send_item(CMD_CONVERT, 4'h0, 8'h90, 8'h88, 8'h84, 1'b0);
        send_item(CMD_CONVERT, 4'h0, 8'h10, 8'hF0, 8'hF8, 1'b0);
    endtask

    // Color cube codes at the channel extremes and around a level boundary.
    task automatic test_cube();
        set_depth(MODE_CUBE);
        send_item(CMD_CONVERT, 4'h0, 8'h00, 8'h00, 8'h00, 1'b0);
        send_item(CMD_CONVERT, 4'h0, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        send_item(CMD_CONVERT, 4'h0, 8'd51, 8'd50, 8'd204, 1'b0);
        send_item(CMD_CONVERT, 4'h0, 8'd254, 8'd102, 8'd1, 1'b0);
    endtask

    // Direct mode echoes the channels.
    task automatic test_direct();
        set_depth(MODE_DIRECT);
        send_item(CMD_CONVERT, 4'h0, 8'h00, 8'h00, 8'h00, 1'b1);
        send_item(CMD_CONVERT, 4'h0, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_item(CMD_CONVERT, 4'hA, 8'hA5, 8'h5A, 8'hC3, 1'b1);
    endtask

    // Long receiver hold while items keep coming, a pause until all results are in, then more items.
    task automatic test_backpressure();
        depth_mode_t modes [2];
        modes = '{MODE_CUBE, MODE_PALETTE};
        foreach (modes[m]) begin
            set_depth(modes[m]);
            send_burst = 1'b1;
            hold_req = 1'b1;
            for (int i = 0; i < 20; i++) begin
                if (i % 5 == 4) begin
                    send_item(CMD_LOAD, IDX_W'($urandom_range(0, 15)), pick_channel(),
                              pick_channel(), pick_channel(), 1'($urandom_range(0, 1)));
                end else begin
                    send_item(CMD_CONVERT, IDX_W'($urandom_range(0, 15)), pick_channel(),
                              pick_channel(), pick_channel(), 1'($urandom_range(0, 1)));
                end
            end
            send_burst = 1'b0;
            drain_results();
            for (int i = 0; i < 8; i++) begin
                send_item(CMD_CONVERT, 4'h0, pick_channel(), pick_channel(), pick_channel(),
                          1'($urandom_range(0, 1)));
            end
        end
    endtask

    // Random loads and conversions over several depth settings and idling patterns.
    task automatic test_random_traffic();
        depth_mode_t plan [8];
        logic        cmd;
        plan = '{MODE_CUBE, MODE_PALETTE, MODE_DIRECT, MODE_NONE,
                 MODE_PALETTE, MODE_CUBE, MODE_DIRECT, MODE_PALETTE};
        foreach (plan[p]) begin
            set_depth(plan[p]);
            send_burst = ($urandom_range(0, 2) == 0);
            recv_burst = ($urandom_range(0, 2) == 0);
            for (int i = 0; i < 58; i++) begin
                cmd = ($urandom_range(0, 99) < 15) ? CMD_LOAD : CMD_CONVERT;
                send_item(cmd, IDX_W'($urandom_range(0, 15)), pick_channel(), pick_channel(),
                          pick_channel(), 1'($urandom_range(0, 1)));
            end
        end
        send_burst = 1'b0;
        recv_burst = 1'b0;
    endtask

    // Main sequence.
    initial begin
        aresetn   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= MODE_NONE;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        depth_copy = MODE_NONE;
        for (int i = 0; i < PALETTE_ENTRIES; i++) begin
            palette_copy[i] = '0;
        end
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_load_palette();
        test_sixteen_colour();
        test_cube();
        test_direct();
        test_backpressure();
        test_random_traffic();
        drain_results();
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Result receiver: random stalls per transfer, and one long hold when asked.
    initial begin
        int stall;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            stall = draw_gap(recv_burst);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do begin
                @(posedge aclk);
            end while (!(m_tvalid && m_tready));
        end
    end

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    // Compare each result transfer with the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_codes.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual kind %0d data %h",
                         $time, m_tuser, m_tdata);
                error_count++;
            end else begin
                oldest_code = expected_codes.pop_front();
                check_field("kind", oldest_code.kind, m_tuser[1:0]);
                check_field("colour_code", oldest_code.code, m_tdata[7:0]);
                check_field("sgr_number", oldest_code.sgr, m_tdata[14:8]);
                check_field("red_out", oldest_code.red, m_tdata[22:15]);
                check_field("green_out", oldest_code.green, m_tdata[30:23]);
                check_field("blue_out", oldest_code.blue, m_tdata[38:31]);
            end
        end
    end

    // Watchdog: ends the run when no transfer happens for too long.
    initial begin
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

endmodule
